/* design/lobp_pkg.sv */
// level object byte packer: shared types and field widths
// no dependencies; used by every module of the packer
`default_nettype none

package lobp_pkg;

  localparam int unsigned ScreenW  = 5;
  localparam int unsigned CoordW   = 5;
  localparam int unsigned ObjIdW   = 6;
  localparam int unsigned FmtW     = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned ApbAddrW = 3;

  // format codes
  localparam logic [FmtW-1:0] FMT_THREE = 2'd0;
  localparam logic [FmtW-1:0] FMT_FOUR  = 2'd1;
  localparam logic [FmtW-1:0] FMT_FIVE  = 2'd2;
  localparam logic [FmtW-1:0] FMT_SIX   = 2'd3;

  // register byte addresses
  localparam logic [ApbAddrW-1:0] REG_VERTICAL = 3'd0;

  // classified object, handed from the front to the back
  typedef struct packed {
    logic              jump;
    logic [ScreenW-1:0] screen;
    logic [ByteW-1:0]  head_byte;
    logic [ByteW-1:0]  code_byte;
    logic [ByteW-1:0]  set1;
    logic [ByteW-1:0]  set2;
    logic [ByteW-1:0]  set3;
    logic [FmtW-1:0]   fmt;
    logic              last;
  } lobp_desc_t;

endpackage

`default_nettype wire

/* design/lobp_front.sv */
// front end: accepts objects, tracks the previous screen, builds descriptors
// depends on lobp_pkg
`default_nettype none

module lobp_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vertical_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [lobp_pkg::InDataW-1:0]  in_data_i,
  input  wire logic                          in_last_i,
  output lobp_pkg::lobp_desc_t               desc_o,
  output logic                               push_o
);

  logic [lobp_pkg::ScreenW-1:0] prev_q, prev_d;
  logic [lobp_pkg::ScreenW-1:0] screen;
  logic [lobp_pkg::CoordW-1:0]  px, py, x, y;
  logic [lobp_pkg::ObjIdW-1:0]  obj;
  logic                         screen_step;

  // unpack the transfer
  assign screen = in_data_i[4:0];
  assign px     = in_data_i[9:5];
  assign py     = in_data_i[14:10];
  assign obj    = in_data_i[20:15];

  // vertical levels swap the coordinates
  assign x = vertical_i ? py : px;
  assign y = vertical_i ? px : py;

  // screen increment is compared without wrap
  assign screen_step = ({1'b0, screen} == ({1'b0, prev_q} + 6'd1));

  assign push_o = in_valid_i && in_ready_i;

  // descriptor
  always_comb begin
    desc_o.jump      = !screen_step && (screen != prev_q);
    desc_o.screen    = screen;
    desc_o.head_byte = {screen_step, obj[5:4], y};
    desc_o.code_byte = {obj[3:0], x[3:0]};
    desc_o.set1      = in_data_i[30:23];
    desc_o.set2      = in_data_i[38:31];
    desc_o.set3      = in_data_i[46:39];
    desc_o.fmt       = in_data_i[22:21];
    desc_o.last      = in_last_i;
  end

  // previous screen, cleared after a final object
  always_comb begin
    prev_d = prev_q;
    if (push_o) begin
      prev_d = in_last_i ? '0 : screen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  // a jump never goes with the new-screen bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !(desc_o.jump && desc_o.head_byte[7]))
    else $error("jump and new-screen bit together");

  // a final object leaves screen zero behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && in_last_i) |=> (prev_q == '0))
    else $error("previous screen not cleared after final object");

  // without a transfer the screen holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_o |=> $stable(prev_q))
    else $error("previous screen changed without a transfer");

endmodule

`default_nettype wire

/* design/lobp_queue.sv */
// two-entry descriptor queue between front and back
// depends on lobp_pkg
`default_nettype none

module lobp_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lobp_pkg::lobp_desc_t desc_i,
  output logic                      ready_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output lobp_pkg::lobp_desc_t      desc_o
);

  lobp_pkg::lobp_desc_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign desc_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into full queue");

endmodule

`default_nettype wire

/* design/lobp_back.sv */
// back end: steps through the bytes of each descriptor into an output register
// depends on lobp_pkg
`default_nettype none

module lobp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_valid_i,
  input  wire lobp_pkg::lobp_desc_t        q_desc_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [lobp_pkg::ByteW-1:0]       out_byte_o,
  output logic                             out_last_o
);

  // byte sequencer steps
  localparam logic [3:0] STEP_JUMP_SCR = 4'd0;
  localparam logic [3:0] STEP_JUMP_LO  = 4'd1;
  localparam logic [3:0] STEP_JUMP_HI  = 4'd2;
  localparam logic [3:0] STEP_HEAD     = 4'd3;
  localparam logic [3:0] STEP_CODE     = 4'd4;
  localparam logic [3:0] STEP_SET1     = 4'd5;
  localparam logic [3:0] STEP_SET2     = 4'd6;
  localparam logic [3:0] STEP_SET3     = 4'd7;
  localparam logic [3:0] STEP_PAD      = 4'd8;
  localparam logic [3:0] STEP_TERM     = 4'd9;

  logic [3:0]                 step_q, step_d, cur_step, nxt_step;
  logic                       started_q, started_d;
  logic                       emit, done;
  logic [lobp_pkg::ByteW-1:0] cur_byte;
  logic                       out_valid_q;
  logic [lobp_pkg::ByteW-1:0] out_byte_q;
  logic                       out_last_q;

  assign cur_step = started_q ? step_q
                  : (q_desc_i.jump ? STEP_JUMP_SCR : STEP_HEAD);
  assign emit     = q_valid_i && (!out_valid_q || out_ready_i);

  // byte select and next step
  always_comb begin
    cur_byte = 8'h00;
    nxt_step = STEP_TERM;
    done     = 1'b0;
    case (cur_step)
      STEP_JUMP_SCR: begin
        cur_byte = {3'b000, q_desc_i.screen};
        nxt_step = STEP_JUMP_LO;
      end
      STEP_JUMP_LO: begin
        cur_byte = 8'h00;
        nxt_step = STEP_JUMP_HI;
      end
      STEP_JUMP_HI: begin
        cur_byte = 8'h01;
        nxt_step = STEP_HEAD;
      end
      STEP_HEAD: begin
        cur_byte = q_desc_i.head_byte;
        nxt_step = STEP_CODE;
      end
      STEP_CODE: begin
        cur_byte = q_desc_i.code_byte;
        nxt_step = STEP_SET1;
      end
      STEP_SET1: begin
        cur_byte = q_desc_i.set1;
        if (q_desc_i.fmt != lobp_pkg::FMT_THREE) begin
          nxt_step = STEP_SET2;
        end else begin
          done = !q_desc_i.last;
        end
      end
      STEP_SET2: begin
        cur_byte = q_desc_i.set2;
        if (q_desc_i.fmt inside {lobp_pkg::FMT_FIVE, lobp_pkg::FMT_SIX}) begin
          nxt_step = STEP_SET3;
        end else begin
          done = !q_desc_i.last;
        end
      end
      STEP_SET3: begin
        cur_byte = q_desc_i.set3;
        if (q_desc_i.fmt == lobp_pkg::FMT_SIX) begin
          nxt_step = STEP_PAD;
        end else begin
          done = !q_desc_i.last;
        end
      end
      STEP_PAD: begin
        cur_byte = 8'h00;
        done     = !q_desc_i.last;
      end
      STEP_TERM: begin
        cur_byte = 8'hFF;
        done     = 1'b1;
      end
      default: begin
        cur_byte = 8'h00;
        done     = 1'b1;
      end
    endcase
  end

  assign pop_o = emit && done;

  // sequencer state
  always_comb begin
    step_d    = step_q;
    started_d = started_q;
    if (emit) begin
      step_d    = nxt_step;
      started_d = !done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_HEAD;
      started_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      started_q <= started_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // a started object stays at the head of the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> q_valid_i)
    else $error("sequencer running without a descriptor");

  // the terminator always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_step == STEP_TERM) |-> pop_o)
    else $error("terminator not last byte");

  // a pop only comes with a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_last_q))
    else $error("pop without closing byte");

endmodule

`default_nettype wire

/* design/level_object_byte_packer_top.sv */
// level object byte packer top: register port, front, queue and back
// depends on lobp_pkg, lobp_front, lobp_queue, lobp_back
`default_nettype none

// Takes one level object per input transfer and sends its encoded bytes, one
// byte per output transfer, with tlast on the last byte of each object. A
// screen jump (screen, 0x00, 0x01) precedes the object when its screen is
// neither the previous one nor the previous one plus one; a final object
// (input tlast) is closed by 0xFF and resets the remembered screen to 0. An
// object produces 3 to 10 bytes, sent by the single byte-per-cycle output
// sequencer unless the output stalls, when a two-entry queue lets the input
// keep accepting; objects follow one another with no gap. Register 0 at byte
// address 0 (bit 0) selects vertical levels, which swap X and Y; the user
// must write it only while the block is idle; the block does not enforce it.
module level_object_byte_packer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lobp_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // objects in
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // screen_index[4:0], pos_x[9:5], pos_y[14:10], object_id[20:15],
  // format_code[22:21], setting_one[30:23], setting_two[38:31],
  // setting_three[46:39], zero[47]
  input  wire logic [lobp_pkg::InDataW-1:0]      s_axis_tdata,
  input  wire logic                              s_axis_tlast,
  // bytes out
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // out_byte[7:0]
  output logic [lobp_pkg::ByteW-1:0]             m_axis_tdata,
  output logic                                   m_axis_tlast
);

  logic                 vertical_q;
  logic                 push, pop, q_ready, q_valid;
  lobp_pkg::lobp_desc_t front_desc, q_desc;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == lobp_pkg::REG_VERTICAL) ? {31'd0, vertical_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertical_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == lobp_pkg::REG_VERTICAL) begin
      vertical_q <= pwdata[0];
    end
  end

  assign s_axis_tready = q_ready;

  lobp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vertical_i (vertical_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (q_ready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .desc_o     (front_desc),
    .push_o     (push)
  );

  lobp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  lobp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_level_object_byte_packer_top.sv */
// testbench for the level object byte packer: random and directed objects in,
// encoded bytes checked against an in-bench encoder; depends on lobp_pkg and the top
`default_nettype none

module tb_level_object_byte_packer_top;

  typedef logic [lobp_pkg::ScreenW-1:0] screen_t;
  typedef logic [lobp_pkg::CoordW-1:0]  coord_t;
  typedef logic [lobp_pkg::ObjIdW-1:0]  obj_id_t;
  typedef logic [lobp_pkg::FmtW-1:0]    fmt_t;
  typedef logic [lobp_pkg::ByteW-1:0]   byte_t;

  localparam byte_t       NEW_SCREEN_BIT = 8'h80;
  localparam byte_t       JUMP_MID       = 8'h00;
  localparam byte_t       JUMP_TAIL      = 8'h01;
  localparam byte_t       SKIPPED_BYTE   = 8'h00;
  localparam byte_t       TERMINATOR     = 8'hFF;
  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    screen_t screen;
    coord_t  pos_x;
    coord_t  pos_y;
    obj_id_t obj_id;
    fmt_t    fmt;
    byte_t   set1;
    byte_t   set2;
    byte_t   set3;
    logic    final_obj;
  } level_obj_t;

  typedef struct packed {
    byte_t value;
    logic  run_end;
  } stream_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [lobp_pkg::ApbAddrW-1:0] paddr   = '0;
  logic [31:0]                   pwdata  = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [lobp_pkg::InDataW-1:0] s_tdata = '0;
  logic                         s_tlast = 1'b0;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  byte_t                        m_tdata;
  logic                         m_tlast;

  level_object_byte_packer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    // screen_index, pos_x, pos_y, object_id, format_code, setting_one..three, zero
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    // out_byte
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  // encoder state, objects waiting to be sent, bytes waiting to arrive
  level_obj_t   pending_objs[$];
  stream_byte_t expected_bytes[$];
  level_obj_t   cur_obj;
  logic         vertical_mode = 1'b0;
  screen_t      last_screen = '0;
  screen_t      gen_screen  = '0;

  int unsigned fail_count  = 0;
  int unsigned objs_in     = 0;
  int unsigned bytes_out   = 0;
  int unsigned jump_count  = 0;
  int unsigned final_count = 0;
  int unsigned vert_objs   = 0;

  logic        calm = 1'b0;
  int unsigned calm_left = 0;
  logic        apb_busy = 1'b0;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // expected bytes of one object, updates the remembered screen
  function automatic void encode_object(level_obj_t o);
    logic   step_up;
    coord_t cx;
    coord_t cy;
    byte_t  bytes[$];
    step_up = (int'(o.screen) == int'(last_screen) + 1);
    if (!step_up && o.screen != last_screen) begin
      bytes.push_back({3'b000, o.screen});
      bytes.push_back(JUMP_MID);
      bytes.push_back(JUMP_TAIL);
      jump_count++;
    end
    cx = vertical_mode ? o.pos_y : o.pos_x;
    cy = vertical_mode ? o.pos_x : o.pos_y;
    bytes.push_back((step_up ? NEW_SCREEN_BIT : 8'h00) | {1'b0, o.obj_id[5:4], cy});
    bytes.push_back({o.obj_id[3:0], cx[3:0]});
    bytes.push_back(o.set1);
    if (o.fmt != lobp_pkg::FMT_THREE) bytes.push_back(o.set2);
    if (o.fmt == lobp_pkg::FMT_FIVE || o.fmt == lobp_pkg::FMT_SIX) bytes.push_back(o.set3);
    if (o.fmt == lobp_pkg::FMT_SIX) bytes.push_back(SKIPPED_BYTE);
    if (o.final_obj) begin
      bytes.push_back(TERMINATOR);
      last_screen = '0;
      final_count++;
    end else begin
      last_screen = o.screen;
    end
    foreach (bytes[i]) expected_bytes.push_back({bytes[i], i == bytes.size() - 1});
  endfunction

  function automatic level_obj_t mk_obj(int scr, int px, int py, int id, fmt_t f,
                                        int b1, int b2, int b3, bit fin);
    level_obj_t o;
    o = '{screen_t'(scr), coord_t'(px), coord_t'(py), obj_id_t'(id), f,
          byte_t'(b1), byte_t'(b2), byte_t'(b3), fin};
    return o;
  endfunction

  // random object, screen biased toward same and next so both paths get exercised
  function automatic level_obj_t random_object();
    level_obj_t  o;
    int unsigned r;
    r = $urandom_range(0, 99);
    o.screen    = (r < 35) ? gen_screen :
                  (r < 70) ? screen_t'(gen_screen + 1'b1) : screen_t'($urandom_range(0, 31));
    o.pos_x     = coord_t'($urandom_range(0, 31));
    o.pos_y     = coord_t'($urandom_range(0, 31));
    o.obj_id    = obj_id_t'($urandom_range(0, 63));
    o.fmt       = fmt_t'($urandom_range(0, 3));
    o.set1      = byte_t'($urandom_range(0, 255));
    o.set2      = byte_t'($urandom_range(0, 255));
    o.set3      = byte_t'($urandom_range(0, 255));
    o.final_obj = ($urandom_range(0, 99) < 8);
    gen_screen  = o.final_obj ? '0 : o.screen;
    return o;
  endfunction

  // stretches with no idling on either side
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // object driver
  always @(posedge clk_i) begin : obj_driver
    int unsigned gap_left;
    level_obj_t  nxt;
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      gap_left = 0;
    end else if (!s_valid || s_ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_valid  <= 1'b0;
      end else if (pending_objs.size() != 0) begin
        nxt      = pending_objs.pop_front();
        cur_obj  <= nxt;
        s_valid  <= 1'b1;
        s_tdata  <= {1'b0, nxt.set3, nxt.set2, nxt.set1, nxt.fmt, nxt.obj_id,
                     nxt.pos_y, nxt.pos_x, nxt.screen};
        s_tlast  <= nxt.final_obj;
        gap_left = calm ? 0 : pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // byte receiver, with one long hold-off once the stream is busy
  always @(posedge clk_i) begin : byte_sink
    int unsigned stall_left;
    int unsigned hold_left;
    bit          held;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
    end else if (!held && objs_in >= 60) begin
      held      = 1'b1;
      hold_left = 300;
      m_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_ready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin : monitor
    stream_byte_t exp_b;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        encode_object(cur_obj);
        objs_in++;
        if (vertical_mode) vert_objs++;
      end
      if (m_valid && m_ready) begin
        bytes_out++;
        if (expected_bytes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected byte 0x%02h last=%0b", m_tdata, m_tlast);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (m_tdata !== exp_b.value || m_tlast !== exp_b.run_end) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"byte %0d mismatch: out_byte exp 0x%02h got 0x%02h, ",
                        "run_end exp %0b got %0b"},
                       bytes_out, exp_b.value, m_tdata, exp_b.run_end, m_tlast);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin : watchdog
    int unsigned idle;
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready) || apb_busy) begin
      idle = 0;
    end else begin
      idle = idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d bytes still expected", idle,
                 expected_bytes.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // register write followed by a read-back
  task automatic write_vertical(logic val);
    logic [31:0] rd;
    apb_busy <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lobp_pkg::REG_VERTICAL;
    pwdata  <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    vertical_mode = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    apb_busy <= 1'b0;
    if (rd[0] !== val) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("vertical register read-back: exp %0b got %0b", val, rd[0]);
    end
  endtask

  // wait until every queued object has gone out and every byte has come back
  task automatic drain();
    @(negedge clk_i);
    while (pending_objs.size() != 0 || s_valid || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_objs.push_back(random_object());
  endtask

  // stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // horizontal level: screen cases, formats and field extremes
    pending_objs.push_back(mk_obj(0, 31, 31, 63, lobp_pkg::FMT_THREE, 255, 0, 0, 0));
    pending_objs.push_back(mk_obj(1, 0, 0, 0, lobp_pkg::FMT_FOUR, 0, 255, 0, 0));
    pending_objs.push_back(mk_obj(1, 16, 15, 48, lobp_pkg::FMT_FIVE, 170, 85, 255, 0));
    pending_objs.push_back(mk_obj(3, 15, 16, 15, lobp_pkg::FMT_SIX, 255, 255, 255, 0));
    pending_objs.push_back(mk_obj(31, 0, 0, 0, lobp_pkg::FMT_THREE, 0, 0, 0, 0));
    pending_objs.push_back(mk_obj(0, 31, 0, 32, lobp_pkg::FMT_FOUR, 1, 2, 3, 0));
    pending_objs.push_back(mk_obj(5, 10, 21, 21, lobp_pkg::FMT_SIX, 85, 170, 85, 1));
    pending_objs.push_back(mk_obj(1, 21, 10, 42, lobp_pkg::FMT_THREE, 128, 0, 0, 0));
    pending_objs.push_back(mk_obj(1, 7, 7, 7, lobp_pkg::FMT_THREE, 127, 0, 0, 1));
    pending_objs.push_back(mk_obj(0, 1, 2, 3, lobp_pkg::FMT_FIVE, 4, 5, 6, 0));
    pending_objs.push_back(mk_obj(30, 30, 29, 61, lobp_pkg::FMT_FOUR, 9, 8, 7, 0));
    pending_objs.push_back(mk_obj(31, 3, 4, 16, lobp_pkg::FMT_THREE, 200, 0, 0, 0));
    pending_objs.push_back(mk_obj(2, 31, 31, 63, lobp_pkg::FMT_SIX, 255, 255, 255, 1));
    drain();

    // vertical level: swapped coordinates
    write_vertical(1'b1);
    pending_objs.push_back(mk_obj(0, 21, 10, 33, lobp_pkg::FMT_THREE, 17, 0, 0, 0));
    pending_objs.push_back(mk_obj(1, 31, 0, 63, lobp_pkg::FMT_FOUR, 255, 1, 0, 0));
    pending_objs.push_back(mk_obj(4, 0, 31, 0, lobp_pkg::FMT_SIX, 0, 0, 0, 0));
    pending_objs.push_back(mk_obj(4, 15, 16, 12, lobp_pkg::FMT_FIVE, 34, 51, 68, 1));
    queue_random(110);
    drain();

    write_vertical(1'b0);
    gen_screen = last_screen;
    queue_random(110);
    drain();

    write_vertical(1'b1);
    queue_random(110);
    drain();

    $display("%0d objects (%0d vertical), %0d bytes, %0d screen jumps, %0d final objects",
             objs_in, vert_objs, bytes_out, jump_count, final_count);
    if (expected_bytes.size() != 0) begin
      fail_count++;
      $display("%0d expected bytes never arrived", expected_bytes.size());
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* level_object_byte_packer_top.f */
design/lobp_pkg.sv
design/lobp_front.sv
design/lobp_queue.sv
design/lobp_back.sv
design/level_object_byte_packer_top.sv
tb/sv/tb_level_object_byte_packer_top.sv
